// File: hw/rtl/rational_sum_accumulator_defines.svh
// Assertion macros for the checker file of the rational sum accumulator.
// No dependencies.
`ifndef RATIONAL_SUM_ACCUMULATOR_DEFINES_SVH
`define RATIONAL_SUM_ACCUMULATOR_DEFINES_SVH

`define RSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational sum accumulator check failed");

`define RSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational sum accumulator check failed");

`endif

// File: hw/rtl/rsa_pkg.sv
// Package for the rational sum accumulator: sequencer states, unit status type,
// widths and helper functions. No dependencies.
package rsa_pkg;

    localparam int RSA_TERM_WIDTH = 32;
    localparam int RSA_W          = 64;
    localparam int RSA_CNT_W      = $clog2(RSA_W + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_G1,
        ST_G1_DIV,
        ST_Q1_DIV,
        ST_Q2_DIV,
        ST_M_LCM,
        ST_M_P1,
        ST_M_P2,
        ST_COMBINE,
        ST_G2,
        ST_G2_DIV,
        ST_R_DIV,
        ST_L_DIV,
        ST_OUT_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    function automatic logic uses_div(input t_state s);
        logic r;
        r = (s == ST_G1_DIV) || (s == ST_G2_DIV) || (s == ST_Q1_DIV) ||
            (s == ST_Q2_DIV) || (s == ST_R_DIV) || (s == ST_L_DIV) || (s == ST_OUT_DIV);
        return r;
    endfunction

    function automatic logic uses_mul(input t_state s);
        logic r;
        r = (s == ST_M_LCM) || (s == ST_M_P1) || (s == ST_M_P2);
        return r;
    endfunction

    // A sign and magnitude pair fits in 64-bit two's complement.
    function automatic logic fits(input logic neg, input logic [RSA_W-1:0] mag);
        logic r;
        r = neg ? (mag <= {1'b1, {(RSA_W-1){1'b0}}}) : !mag[RSA_W-1];
        return r;
    endfunction

endpackage

// File: hw/rtl/rational_sum_accumulator.sv
// Rational sum accumulator: sequencer over a shared divider and multiplier.
// Each divide or multiply holds the sequencer until done; each Euclid step adds a G state.
// A beat with a nonzero denominator and no overflow runs two GCDs, three multiplies and
// four divides; a last beat adds a divide for the whole part and an emit state.
// One beat at a time; the output register lets a result wait while the next beat enters.
// Synchronous active-low reset clears the sum to 0/1, the overflow flag and all handshakes.
module rational_sum_accumulator #(
    parameter int TERM_WIDTH = rsa_pkg::RSA_TERM_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [31:0]        i_numerator,
    input  logic [30:0]               i_denominator,
    input  logic                      i_last_term,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [63:0]        o_whole_part,
    output logic signed [63:0]        o_frac_numerator,
    output logic [62:0]               o_frac_denominator,
    output logic                      o_overflow
);
    import rsa_pkg::*;

    t_state                r_state, n_state;
    logic                  r_kick;
    logic [RSA_W-1:0]      r_sum_num, r_sum_den;
    logic                  r_ovf;
    logic                  r_tneg, r_last, r_rneg;
    logic [TERM_WIDTH-1:0] r_tmag;
    logic [TERM_WIDTH-2:0] r_tden;
    logic [RSA_W-1:0]      r_a, r_b, r_q1, r_q2, r_lcm, r_p1, r_rmag;
    logic                  r_o_valid;
    logic [63:0]           r_o_whole, r_o_fnum;
    logic [62:0]           r_o_fden;
    logic                  r_o_ovf;

    logic [TERM_WIDTH-1:0] in_nbits, in_tmag;
    logic [TERM_WIDTH-2:0] in_tden;
    logic                  accept, sneg;
    logic [RSA_W-1:0]      smag, tden64, tmag64;
    logic                  div_start, mul_start;
    logic [RSA_W-1:0]      div_a, div_b, mul_a, mul_b;
    t_unit_stat            div_stat, mul_stat;
    logic [RSA_W-1:0]      div_q, div_r, mul_hi, mul_lo;
    logic                  lcm_bad, p1_bad, p2_bad, cmb_bad, cmb_rneg, out_free;
    logic [RSA_W:0]        cmb_sum;
    logic [RSA_W-1:0]      cmb_rmag;

    assign in_nbits = i_numerator[TERM_WIDTH-1:0];
    assign in_tmag  = in_nbits[TERM_WIDTH-1] ? (~in_nbits + 1'b1) : in_nbits;
    assign in_tden  = i_denominator[TERM_WIDTH-2:0];
    assign accept   = i_valid && o_ready;
    assign sneg     = r_sum_num[RSA_W-1];
    assign smag     = sneg ? (~r_sum_num + 1'b1) : r_sum_num;
    assign tden64   = {{(RSA_W-TERM_WIDTH+1){1'b0}}, r_tden};
    assign tmag64   = {{(RSA_W-TERM_WIDTH){1'b0}}, r_tmag};
    assign out_free = !r_o_valid || i_ready;

    assign lcm_bad = (mul_hi != '0) || mul_lo[RSA_W-1];
    assign p1_bad  = (mul_hi != '0) || !fits(sneg, mul_lo);
    assign p2_bad  = (mul_hi != '0) || !fits(r_tneg, mul_lo);

    always_comb begin
        cmb_sum  = '0;
        cmb_rneg = sneg;
        cmb_rmag = '0;
        cmb_bad  = 1'b0;
        if (sneg == r_tneg) begin
            cmb_sum  = {1'b0, r_p1} + {1'b0, r_q2};
            cmb_rmag = cmb_sum[RSA_W-1:0];
            cmb_bad  = cmb_sum[RSA_W];
        end else if (r_p1 >= r_q2) begin
            cmb_rmag = r_p1 - r_q2;
        end else begin
            cmb_rneg = r_tneg;
            cmb_rmag = r_q2 - r_p1;
        end
        cmb_bad = cmb_bad || !fits(cmb_rneg, cmb_rmag);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (in_tden != '0) begin
                        n_state = ST_G1;
                    end else if (i_last_term) begin
                        n_state = ST_OUT_DIV;
                    end
                end
            end
            ST_G1:      n_state = (r_b == '0) ? ST_Q1_DIV : ST_G1_DIV;
            ST_G1_DIV:  if (div_stat.done) n_state = ST_G1;
            ST_Q1_DIV:  if (div_stat.done) n_state = ST_Q2_DIV;
            ST_Q2_DIV:  if (div_stat.done) n_state = ST_M_LCM;
            ST_M_LCM: begin
                if (mul_stat.done) begin
                    n_state = lcm_bad ? (r_last ? ST_OUT_DIV : ST_IDLE) : ST_M_P1;
                end
            end
            ST_M_P1: begin
                if (mul_stat.done) begin
                    n_state = p1_bad ? (r_last ? ST_OUT_DIV : ST_IDLE) : ST_M_P2;
                end
            end
            ST_M_P2: begin
                if (mul_stat.done) begin
                    n_state = p2_bad ? (r_last ? ST_OUT_DIV : ST_IDLE) : ST_COMBINE;
                end
            end
            ST_COMBINE: n_state = cmb_bad ? (r_last ? ST_OUT_DIV : ST_IDLE) : ST_G2;
            ST_G2:      n_state = (r_b == '0) ? ST_R_DIV : ST_G2_DIV;
            ST_G2_DIV:  if (div_stat.done) n_state = ST_G2;
            ST_R_DIV:   if (div_stat.done) n_state = ST_L_DIV;
            ST_L_DIV:   if (div_stat.done) n_state = r_last ? ST_OUT_DIV : ST_IDLE;
            ST_OUT_DIV: if (div_stat.done) n_state = ST_EMIT;
            ST_EMIT:    if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = (r_state == ST_IDLE);
        div_start = r_kick && uses_div(r_state);
        mul_start = r_kick && uses_mul(r_state);
        div_a     = r_a;
        div_b     = r_b;
        mul_a     = r_q1;
        mul_b     = tden64;
        unique case (r_state)
            ST_Q1_DIV:  begin div_a = r_sum_den; div_b = r_a; end
            ST_Q2_DIV:  begin div_a = tden64;    div_b = r_a; end
            ST_R_DIV:   begin div_a = r_rmag;    div_b = r_a; end
            ST_L_DIV:   begin div_a = r_lcm;     div_b = r_a; end
            ST_OUT_DIV: begin div_a = smag;      div_b = r_sum_den; end
            ST_M_P1:    begin mul_a = smag;      mul_b = r_q2; end
            ST_M_P2:    begin mul_a = tmag64;    mul_b = r_q1; end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_kick    <= 1'b0;
            r_sum_num <= '0;
            r_sum_den <= RSA_W'(1);
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kick  <= (n_state != r_state) && (uses_div(n_state) || uses_mul(n_state));
            if (r_o_valid && i_ready && !((r_state == ST_EMIT) && out_free)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_tneg <= in_nbits[TERM_WIDTH-1];
                        r_tmag <= in_tmag;
                        r_tden <= in_tden;
                        r_last <= i_last_term;
                        r_a    <= {{(RSA_W-TERM_WIDTH+1){1'b0}}, in_tden};
                        r_b    <= r_sum_den;
                    end
                end
                ST_G1_DIV, ST_G2_DIV: begin
                    if (div_stat.done) begin
                        r_a <= r_b;
                        r_b <= div_r;
                    end
                end
                ST_Q1_DIV: if (div_stat.done) r_q1 <= div_q;
                ST_Q2_DIV: if (div_stat.done) r_q2 <= div_q;
                ST_M_LCM: begin
                    if (mul_stat.done) begin
                        if (lcm_bad) r_ovf <= 1'b1;
                        r_lcm <= mul_lo;
                    end
                end
                ST_M_P1: begin
                    if (mul_stat.done) begin
                        if (p1_bad) r_ovf <= 1'b1;
                        r_p1 <= mul_lo;
                    end
                end
                ST_M_P2: begin
                    if (mul_stat.done) begin
                        if (p2_bad) r_ovf <= 1'b1;
                        r_q2 <= mul_lo;
                    end
                end
                ST_COMBINE: begin
                    if (cmb_bad) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_rneg <= cmb_rneg;
                        r_rmag <= cmb_rmag;
                        r_a    <= cmb_rmag;
                        r_b    <= r_lcm;
                    end
                end
                ST_R_DIV: if (div_stat.done) r_rmag <= div_q;
                ST_L_DIV: begin
                    if (div_stat.done) begin
                        r_sum_num <= r_rneg ? (~r_rmag + 1'b1) : r_rmag;
                        r_sum_den <= div_q;
                    end
                end
                ST_OUT_DIV: begin
                    if (div_stat.done) begin
                        r_q1 <= div_q;
                        r_q2 <= div_r;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_whole <= sneg ? (~r_q1 + 1'b1) : r_q1;
                        r_o_fnum  <= sneg ? (~r_q2 + 1'b1) : r_q2;
                        r_o_fden  <= (r_q2 == '0) ? 63'd1 : r_sum_den[62:0];
                        r_o_ovf   <= r_ovf;
                        r_sum_num <= '0;
                        r_sum_den <= RSA_W'(1);
                        r_ovf     <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    rsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_stat     (div_stat),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    rsa_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_a),
        .i_mplier (mul_b),
        .o_stat   (mul_stat),
        .o_hi     (mul_hi),
        .o_lo     (mul_lo)
    );

    assign o_valid            = r_o_valid;
    assign o_whole_part       = r_o_whole;
    assign o_frac_numerator   = r_o_fnum;
    assign o_frac_denominator = r_o_fden;
    assign o_overflow         = r_o_ovf;
endmodule

// File: hw/rtl/rsa_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned 64 by 64 bits.
// Depends on rsa_pkg.
module rsa_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rsa_pkg::RSA_W-1:0] i_dividend,
    input  logic [rsa_pkg::RSA_W-1:0] i_divisor,
    output rsa_pkg::t_unit_stat       o_stat,
    output logic [rsa_pkg::RSA_W-1:0] o_quot,
    output logic [rsa_pkg::RSA_W-1:0] o_rem
);
    import rsa_pkg::*;

    logic [RSA_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [RSA_W-1:0]     r_rem;
    logic [RSA_W-1:0]     r_quo;
    logic [RSA_W-1:0]     r_dvs;
    logic [RSA_W:0]       trial;
    logic [RSA_W:0]       diff;

    assign trial = {r_rem, r_quo[RSA_W-1]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= RSA_CNT_W'(RSA_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                if (!diff[RSA_W]) begin
                    r_rem <= diff[RSA_W-1:0];
                    r_quo <= {r_quo[RSA_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial[RSA_W-1:0];
                    r_quo <= {r_quo[RSA_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == RSA_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;
    assign o_rem       = r_rem;
endmodule

// File: hw/rtl/rsa_mul.sv
// Shared shift-add multiplier, one multiplier bit per cycle, 64 by 64 to 128 bits.
// Depends on rsa_pkg.
module rsa_mul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rsa_pkg::RSA_W-1:0] i_mcand,
    input  logic [rsa_pkg::RSA_W-1:0] i_mplier,
    output rsa_pkg::t_unit_stat       o_stat,
    output logic [rsa_pkg::RSA_W-1:0] o_hi,
    output logic [rsa_pkg::RSA_W-1:0] o_lo
);
    import rsa_pkg::*;

    logic [RSA_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [RSA_W-1:0]     r_hi;
    logic [RSA_W-1:0]     r_lo;
    logic [RSA_W-1:0]     r_mc;
    logic [RSA_W:0]       sum;

    assign sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mc} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= RSA_CNT_W'(RSA_W);
                r_hi   <= '0;
                r_lo   <= i_mplier;
                r_mc   <= i_mcand;
            end else if (r_busy) begin
                r_hi  <= sum[RSA_W:1];
                r_lo  <= {sum[0], r_lo[RSA_W-1:1]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == RSA_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_hi        = r_hi;
    assign o_lo        = r_lo;
endmodule

// File: hw/rtl/rsa_checker.sv
// Port-level checks for the rational sum accumulator, bound to the top level.
// Depends on rational_sum_accumulator_defines.svh.
`include "rational_sum_accumulator_defines.svh"
module rsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_last_term,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_whole_part,
    input logic [63:0] o_frac_numerator,
    input logic [62:0] o_frac_denominator
);
    `RSA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_whole_part) && $stable(o_frac_numerator))
    `RSA_ASSERT_NXT(a_busy_after_last, i_clk, i_rst_n, i_valid && o_ready && i_last_term,
        !o_ready)
    `RSA_ASSERT_IMP(a_den_nonzero, i_clk, i_rst_n, o_valid, o_frac_denominator != 63'd0)
    `RSA_ASSERT_IMP(a_integral_den, i_clk, i_rst_n, o_valid && (o_frac_numerator == 64'd0),
        o_frac_denominator == 63'd1)
endmodule

bind rational_sum_accumulator rsa_checker u_rsa_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_ready            (o_ready),
    .i_last_term        (i_last_term),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_whole_part       (o_whole_part),
    .o_frac_numerator   (o_frac_numerator),
    .o_frac_denominator (o_frac_denominator)
);

// File: tb/tb_top.sv
// Self-checking testbench for rational_sum_accumulator: directed, back-pressure and random tests.
// A built-in predictor of the fraction sum checks each result; depends on the RTL only.
module tb_top;

    localparam int  HOLD_CYCLES = 20000;
    localparam int  DRAIN_CYCLES = 20000;
    localparam longint CYCLE_LIMIT = 40000000;

    typedef struct packed {
        logic signed [63:0] whole;
        logic signed [63:0] frac_num;
        logic [62:0]        frac_den;
        logic               ovf;
    } t_mixed;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_numerator = '0;
    logic [30:0]        i_denominator = 31'd1;
    logic               i_last_term = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [63:0] o_whole_part;
    logic signed [63:0] o_frac_numerator;
    logic [62:0]        o_frac_denominator;
    logic               o_overflow;

    logic [63:0] acc_num = '0;
    logic [63:0] acc_den = 64'd1;
    logic        acc_ovf = 1'b0;
    t_mixed      sums_due[$];
    int          errors = 0;
    longint      cycles = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    logic        rx_blocked = 1'b0;
    int          rx_wait = 0;
    event        hold_go;

    rational_sum_accumulator u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [63:0] euclid(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic bit mul_fits(input logic [63:0] a, input logic [63:0] b,
                                    output logic [63:0] r);
        logic [127:0] p;
        p = a * b;
        r = p[63:0];
        return p[127:64] == 0;
    endfunction

    function automatic bit in_range(input bit neg, input logic [63:0] mag);
        return neg ? (mag <= 64'h8000_0000_0000_0000) : !mag[63];
    endfunction

    function automatic void add_fraction(input bit tneg, input logic [63:0] tmag,
                                         input logic [63:0] tden);
        bit          sneg, rneg;
        logic [63:0] smag, g, lcm, p1, p2, rmag, g2;
        sneg = acc_num[63];
        smag = sneg ? -acc_num : acc_num;
        if (tden == 0) return;
        g = euclid(tden, acc_den);
        if (!mul_fits(acc_den / g, tden, lcm) || lcm[63]) begin
            acc_ovf = 1'b1;
            return;
        end
        if (!mul_fits(smag, tden / g, p1) || !in_range(sneg, p1) ||
            !mul_fits(tmag, acc_den / g, p2) || !in_range(tneg, p2)) begin
            acc_ovf = 1'b1;
            return;
        end
        if (sneg == tneg) begin
            rneg = sneg;
            if (p1 > ~p2) begin
                acc_ovf = 1'b1;
                return;
            end
            rmag = p1 + p2;
        end else if (p1 >= p2) begin
            rneg = sneg;
            rmag = p1 - p2;
        end else begin
            rneg = tneg;
            rmag = p2 - p1;
        end
        if (!in_range(rneg, rmag)) begin
            acc_ovf = 1'b1;
            return;
        end
        g2 = euclid(rmag, lcm);
        rmag = rmag / g2;
        acc_num = rneg ? -rmag : rmag;
        acc_den = lcm / g2;
    endfunction

    function automatic void predict_sum(input logic [31:0] num, input logic [30:0] den,
                                        input logic last);
        bit          neg;
        logic [63:0] mag, wmag, rmag;
        t_mixed      m;
        neg = num[31];
        mag = neg ? -{{32{num[31]}}, num} : {32'd0, num};
        add_fraction(neg, mag, {33'd0, den});
        if (!last) return;
        neg = acc_num[63];
        mag = neg ? -acc_num : acc_num;
        wmag = mag / acc_den;
        rmag = mag % acc_den;
        m.whole = neg ? -wmag : wmag;
        m.frac_num = neg ? -rmag : rmag;
        m.frac_den = (rmag == 0) ? 63'd1 : acc_den[62:0];
        m.ovf = acc_ovf;
        sums_due.push_back(m);
        acc_num = '0;
        acc_den = 64'd1;
        acc_ovf = 1'b0;
    endfunction

    task automatic send_term(input logic [31:0] num, input logic [30:0] den, input logic last);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_numerator <= num;
        i_denominator <= den;
        i_last_term <= last;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        predict_sum(num, den, last);
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            rx_wait <= rx_idle_on ? $urandom_range(0, 10) : 0;
            i_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !rx_blocked && i_rst_n;
        end
    end

    initial begin
        forever begin
            @(hold_go);
            @(posedge i_clk);
            rx_blocked <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_blocked <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_mixed m;
        if (i_rst_n && o_valid && i_ready) begin
            if (sums_due.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                m = sums_due.pop_front();
                if (o_whole_part !== m.whole) begin
                    $error("whole_part exp %0d got %0d", m.whole, o_whole_part);
                    errors++;
                end
                if (o_frac_numerator !== m.frac_num) begin
                    $error("frac_numerator exp %0d got %0d", m.frac_num, o_frac_numerator);
                    errors++;
                end
                if (o_frac_denominator !== m.frac_den) begin
                    $error("frac_denominator exp %0d got %0d", m.frac_den,
                           o_frac_denominator);
                    errors++;
                end
                if (o_overflow !== m.ovf) begin
                    $error("overflow exp %0d got %0d", m.ovf, o_overflow);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_term(32'h8000_0000, 31'd1, 1'b1);
        send_term(32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        send_term(32'h7FFF_FFFF, 31'd1, 1'b0);
        send_term(32'h7FFF_FFFF, 31'd3, 1'b1);
        send_term(32'd5, 31'd0, 1'b1);
        send_term(32'd1, 31'd2, 1'b0);
        send_term(32'd1, 31'd2, 1'b1);
        send_term(-32'sd7, 31'd3, 1'b1);
        send_term(32'd3, 31'd4, 1'b0);
        send_term(-32'sd3, 31'd4, 1'b1);
        send_term(32'd1, 31'h7FFF_FFFF, 1'b0);
        send_term(32'd1, 31'h7FFF_FFFE, 1'b0);
        send_term(32'd1, 31'h7FFF_FFFD, 1'b0);
        send_term(32'd1, 31'd0, 1'b1);
        send_term(32'h8000_0000, 31'd1, 1'b0);
        send_term(32'h8000_0000, 31'd1, 1'b0);
        send_term(32'h8000_0000, 31'd1, 1'b1);
        send_term(32'd0, 31'd5, 1'b1);
        send_term(32'h5555_5555, 31'h2AAA_AAAA, 1'b1);
        send_term(32'h2AAA_AAAA, 31'h5555_5555, 1'b1);
    endtask

    task automatic send_group(input int len);
        logic [31:0] num;
        logic [30:0] den;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                7: begin
                    num = $urandom;
                    den = 31'($urandom);
                end
                8: begin
                    num = $urandom_range(0, 200) - 100;
                    den = 31'd0;
                end
                9: begin
                    num = $urandom_range(0, 2000) - 1000;
                    den = 31'($urandom_range(1, 100000));
                end
                default: begin
                    num = $urandom_range(0, 200) - 100;
                    den = 31'($urandom_range(1, 60));
                end
            endcase
            send_term(num, den, k == len - 1);
        end
    endtask

    task automatic test_backpressure();
        -> hold_go;
        tx_idle_on = 1'b0;
        repeat (6) send_group($urandom_range(1, 3));
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random();
        int sent;
        int len;
        sent = 0;
        while (sent < 900) begin
            len = $urandom_range(1, 6);
            tx_idle_on = ($urandom_range(0, 7) != 0);
            rx_idle_on = ($urandom_range(0, 7) != 0);
            send_group(len);
            sent += len;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        i_valid <= 1'b0;
        while (sums_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sums_due.size() != 0) errors++;
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rsa_pkg.sv
hw/rtl/rsa_div.sv
hw/rtl/rsa_mul.sv
hw/rtl/rational_sum_accumulator.sv
hw/rtl/rsa_checker.sv
tb/tb_top.sv
